// ----- hdl/deck_shuffle_engine_assert.svh -----
// ----------------------------------------------------------------------------
// deck_shuffle_engine_assert.svh
// Assertion macros used by the checker file of the shuffle engine.
// ----------------------------------------------------------------------------
`ifndef DECK_SHUFFLE_ENGINE_ASSERT_SVH
`define DECK_SHUFFLE_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deck shuffle engine: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define DSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deck shuffle engine: next-cycle check failed");

`endif

// ----- hdl/dse_pkg.sv -----
// ----------------------------------------------------------------------------
// dse_pkg
// Types, constants and the card decode function of the deck shuffle engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dse_pkg;

  // Store and field widths
  localparam int DSE_DECK_MAX   = 64;
  localparam int DSE_CARD_W     = 6;
  localparam int DSE_SUIT_W     = 2;
  localparam int DSE_RANK_W     = 5;
  localparam int DSE_SUITCFG_W  = 3;
  localparam int DSE_RANKCFG_W  = 5;
  localparam int DSE_RAND_W     = 32;
  localparam int DSE_CFG_IDX_W  = 2;
  localparam int DSE_CFG_DATA_W = 5;

  // Register limits and reset values
  localparam logic [DSE_SUITCFG_W-1:0] DSE_SUIT_MAX   = 3'd4;
  localparam logic [DSE_RANKCFG_W-1:0] DSE_RANK_MAX   = 5'd16;
  localparam logic [DSE_SUITCFG_W-1:0] DSE_SUIT_RESET = 3'd4;
  localparam logic [DSE_RANKCFG_W-1:0] DSE_RANK_RESET = 5'd13;

  // Configuration register indexes
  localparam logic [DSE_CFG_IDX_W-1:0] DSE_REG_SUIT_COUNT = 2'd0;
  localparam logic [DSE_CFG_IDX_W-1:0] DSE_REG_RANK_COUNT = 2'd1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_RD_P  = 8'b0000_0100,
    ST_RD_J  = 8'b0000_1000,
    ST_WR_P  = 8'b0001_0000,
    ST_WR_J  = 8'b0010_0000,
    ST_DEAL  = 8'b0100_0000,
    ST_DRAIN = 8'b1000_0000
  } dse_state_t;

  // Decoded card
  typedef struct packed {
    logic [DSE_SUIT_W-1:0] suit;
    logic [DSE_RANK_W-1:0] rank;
  } dse_card_t;

  // Card number to suit and rank: card / ranks is at most 3, so three
  // compares against 1x, 2x and 3x ranks replace a divider.
  function automatic dse_card_t dse_decode(input logic [DSE_CARD_W-1:0]    card,
                                           input logic [DSE_RANKCFG_W-1:0] ranks);
    logic [6:0] c;
    logic [6:0] r1;
    logic [6:0] r2;
    logic [6:0] r3;
    logic [6:0] rem;
    dse_card_t  res;
    c  = {1'b0, card};
    r1 = {2'b00, ranks};
    r2 = {1'b0, ranks, 1'b0};
    r3 = r1 + r2;
    if (c >= r3) begin
      res.suit = 2'd3;
      rem      = c - r3;
    end else if (c >= r2) begin
      res.suit = 2'd2;
      rem      = c - r2;
    end else if (c >= r1) begin
      res.suit = 2'd1;
      rem      = c - r1;
    end else begin
      res.suit = 2'd0;
      rem      = c;
    end
    res.rank = rem[DSE_RANK_W-1:0] + 5'd1;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dse_ram.sv -----
// ----------------------------------------------------------------------------
// dse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/dse_mod_unit.sv -----
// ----------------------------------------------------------------------------
// dse_mod_unit
// Restoring remainder unit: 32-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dse_mod_unit
  import dse_pkg::*;
#(
  parameter int DIVISOR_W = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DSE_RAND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DSE_RAND_W);

  logic                  running;
  logic [CNT_W-1:0]      count;
  logic [DSE_RAND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {remainder, dvd[DSE_RAND_W-1]};
    diff     = trial - {1'b0, dvs};
    rem_next = (trial >= {1'b0, dvs}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DSE_RAND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (running) begin
      dvd       <= {dvd[DSE_RAND_W-2:0], 1'b0};
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/deck_shuffle_engine.sv -----
// ----------------------------------------------------------------------------
// deck_shuffle_engine
// Fisher-Yates shuffle over a card store RAM, dealt out in stack-pop order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken when start is high and busy is low; it
//   carries one random word for the current shuffle position.
//   Each transaction keeps busy high through the remainder unit (32 steps,
//   one bit per cycle over the random word, then its done pulse) and then
//   through the swap, read p, read j, write p, write j, which reads both
//   entries and writes them back through the single write port. A new
//   transaction is taken only once busy has dropped again.
//   Position deck size - 1 is the last swap; after it the deck is read out
//   from the top entry down, one card per cycle, each card shown for one
//   cycle with card_strobe high and last_card on the bottom card. Busy drops
//   after the drain state that follows the deal. The receiver cannot stall.
//   Configuration: cfg_valid/cfg_ready write channel, ready only while idle.
//   Writing suit_count or rank_count restarts the shuffle at position 0 with
//   the store in identity order.
//   Reset: registers return to 4 suits and 13 ranks, position 0, and every
//   store entry reads as its own index at once through per-entry valid bits,
//   so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module deck_shuffle_engine
  import dse_pkg::*;
#(
  parameter int DECK_MAX = DSE_DECK_MAX
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [DSE_RAND_W-1:0]     random_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [DSE_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DSE_CFG_DATA_W-1:0] cfg_data,
  output logic                           card_strobe,
  output logic      [DSE_SUIT_W-1:0]     card_suit,
  output logic      [DSE_RANK_W-1:0]     card_rank,
  output logic                           last_card
);

  localparam int ADDR_W = (DECK_MAX > 1) ? $clog2(DECK_MAX) : 1;
  localparam int POS_W  = $clog2(DECK_MAX + 1);

  dse_state_t state;
  dse_state_t state_next;

  logic [DSE_SUITCFG_W-1:0] suit_count;
  logic [DSE_RANKCFG_W-1:0] rank_count;
  logic [DSE_SUITCFG_W-1:0] suits_eff;
  logic [DSE_RANKCFG_W-1:0] ranks_eff;
  logic [7:0]               deck_prod;
  logic [POS_W-1:0]         deck_n;
  logic [POS_W-1:0]         deck_last;

  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_eff;
  logic [POS_W-1:0]         pos_inc;
  logic [POS_W-1:0]         j_sum;
  logic [ADDR_W-1:0]        j_addr;
  logic [ADDR_W-1:0]        deal_addr;
  logic [DECK_MAX-1:0]      filled;

  logic                     in_accept;
  logic                     cfg_accept;
  logic                     div_done;
  logic [POS_W-1:0]         div_rem;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DSE_CARD_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DSE_CARD_W-1:0]    ram_rdata;
  logic [ADDR_W-1:0]        rd_addr_q;
  logic                     rd_fill;
  logic [DSE_CARD_W-1:0]    card_rd;
  logic [DSE_CARD_W-1:0]    swap_tmp;
  logic                     rd_live;
  logic                     rd_last;
  dse_card_t                card_dec;

  // Effective deck geometry
  always_comb begin
    if (suit_count == '0) begin
      suits_eff = 3'd1;
    end else if (suit_count > DSE_SUIT_MAX) begin
      suits_eff = DSE_SUIT_MAX;
    end else begin
      suits_eff = suit_count;
    end
    if (rank_count == '0) begin
      ranks_eff = 5'd1;
    end else if (rank_count > DSE_RANK_MAX) begin
      ranks_eff = DSE_RANK_MAX;
    end else begin
      ranks_eff = rank_count;
    end
    deck_prod = {5'b0, suits_eff} * {3'b0, ranks_eff};
    deck_n    = (deck_prod > 8'(DECK_MAX)) ? POS_W'(DECK_MAX) : POS_W'(deck_prod);
    deck_last = deck_n - 1'b1;
  end

  // Handshakes
  assign busy       = (state != ST_IDLE);
  assign in_accept  = start && !busy;
  assign cfg_ready  = (state == ST_IDLE) && !start;
  assign cfg_accept = cfg_valid && cfg_ready;

  // Position bookkeeping
  assign pos_eff = (pos >= deck_n) ? '0 : pos;
  assign pos_inc = pos + 1'b1;
  assign j_sum   = pos + div_rem;

  // Remainder of the random word by the cards still unplaced
  dse_mod_unit #(
    .DIVISOR_W (POS_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .dividend  (random_value),
    .divisor   (deck_n - pos_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Entries never written since the last restore read as their own index
  assign card_rd = rd_fill ? ram_rdata : DSE_CARD_W'(rd_addr_q);

  // RAM port control: swap is read p, read j, write p, write j, in order,
  // so no read that the swap uses overlaps a write to the same entry
  always_comb begin
    ram_we    = (state == ST_WR_P) || (state == ST_WR_J);
    ram_waddr = (state == ST_WR_P) ? pos[ADDR_W-1:0] : j_addr;
    ram_wdata = (state == ST_WR_P) ? card_rd : swap_tmp;
    unique case (state)
      ST_RD_J: ram_raddr = j_addr;
      ST_DEAL: ram_raddr = deal_addr;
      default: ram_raddr = pos[ADDR_W-1:0];
    endcase
  end

  dse_ram #(
    .WIDTH (DSE_CARD_W),
    .DEPTH (DECK_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_accept) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_RD_P;
      ST_RD_P:  state_next = ST_RD_J;
      ST_RD_J:  state_next = ST_WR_P;
      ST_WR_P:  state_next = ST_WR_J;
      ST_WR_J:  state_next = (pos_inc == deck_n) ? ST_DEAL : ST_IDLE;
      ST_DEAL:  if (deal_addr == '0) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_live) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      suit_count  <= DSE_SUIT_RESET;
      rank_count  <= DSE_RANK_RESET;
      pos         <= '0;
      filled      <= '0;
      rd_live     <= 1'b0;
      card_strobe <= 1'b0;
    end else begin
      state       <= state_next;
      rd_live     <= (state == ST_DEAL);
      card_strobe <= rd_live;

      // Register writes restart the shuffle from identity order
      if (cfg_accept) begin
        if (cfg_index == DSE_REG_SUIT_COUNT) begin
          suit_count <= cfg_data[DSE_SUITCFG_W-1:0];
          filled     <= '0;
          pos        <= '0;
        end else if (cfg_index == DSE_REG_RANK_COUNT) begin
          rank_count <= cfg_data[DSE_RANKCFG_W-1:0];
          filled     <= '0;
          pos        <= '0;
        end
      end

      // A stale position past the deck restarts from identity order
      if (in_accept) begin
        pos <= pos_eff;
        if (pos >= deck_n) begin
          filled <= '0;
        end
      end

      if (ram_we) begin
        filled[ram_waddr] <= 1'b1;
      end

      if (state == ST_WR_J) begin
        pos <= (pos_inc == deck_n) ? '0 : pos_inc;
      end

      // Deal done: store back to identity order
      if ((state == ST_DEAL) && (deal_addr == '0)) begin
        filled <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
    rd_fill   <= filled[ram_raddr];
    rd_last   <= (state == ST_DEAL) && (deal_addr == '0);
    if (div_done) begin
      j_addr <= j_sum[ADDR_W-1:0];
    end
    if (state == ST_RD_J) begin
      swap_tmp <= card_rd;
    end
    if ((state == ST_WR_J) && (pos_inc == deck_n)) begin
      deal_addr <= deck_last[ADDR_W-1:0];
    end else if (state == ST_DEAL) begin
      deal_addr <= deal_addr - 1'b1;
    end
  end

  // Card decode and output register
  assign card_dec = dse_decode(card_rd, ranks_eff);

  always_ff @(posedge clk) begin
    if (rd_live) begin
      card_suit <= card_dec.suit;
      card_rank <= card_dec.rank;
      last_card <= rd_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dse_checker.sv -----
// ----------------------------------------------------------------------------
// dse_checker
// Port-level checks of the deck shuffle engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deck_shuffle_engine_assert.svh"

module dse_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic cfg_valid,
  input wire logic cfg_ready,
  input wire logic card_strobe,
  input wire logic last_card
);

  // Cards only come out while a transaction is in progress
  `DSE_ASSERT_NOW(a_strobe_busy, clk, rst, card_strobe, busy)

  // An accepted transaction makes the block busy
  `DSE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // The deal is one unbroken burst that ends on the last card
  `DSE_ASSERT_NEXT(a_burst_cont, clk, rst, card_strobe && !last_card, card_strobe)
  `DSE_ASSERT_NEXT(a_burst_end, clk, rst, card_strobe && last_card, !card_strobe)

  // Register writes only land while idle
  `DSE_ASSERT_NOW(a_cfg_idle, clk, rst, cfg_valid && cfg_ready, !busy)

endmodule

bind deck_shuffle_engine dse_checker u_dse_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .card_strobe (card_strobe),
  .last_card   (last_card)
);

`default_nettype wire
